// ----- sv/msbd_pkg.sv -----
// Shared types, codes and constants for the multi-slot button debouncer.
package msbd_pkg;

  localparam int SLOTS         = 32;
  localparam int PORTS         = 4;
  localparam int PINS_PER_PORT = 16;
  localparam int COUNT_WIDTH   = 8;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int THR_W         = 8;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REPLY_EVENT = 2'd0,
    REPLY_ADD   = 2'd1,
    REPLY_READ  = 2'd2
  } reply_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_WALK,
    ST_END
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] gpio_levels;
    logic [1:0]  port_sel;
    logic [3:0]  pin_sel;
    logic [4:0]  slot_id;
  } msbd_in_t;

  typedef struct packed {
    logic [1:0] reply_kind;
    logic [5:0] slot_num;
    logic       level;
    logic       last;
  } msbd_out_t;

  typedef struct packed {
    logic [1:0]             port;
    logic [3:0]             pin;
    logic                   stable;
    logic [COUNT_WIDTH-1:0] count;
  } slot_entry_t;

  // Pick the bit port*16+pin of the sampled levels
  function automatic logic sample_bit(logic [63:0] levels, logic [1:0] port,
                                      logic [3:0] pin);
    logic [5:0] bidx;
    bidx = {port, pin};
    return levels[bidx];
  endfunction

endpackage

// ----- sv/multi_slot_button_debouncer_unit.sv -----
// Top level of the multi-slot button debouncer: slot table, tick walk and result register.
//
// Input channel (in_valid / in_stall / in_data) carries one transaction per command:
// tick, add binding, remove binding or read level. Result channel (out_valid /
// out_stall / out_data) returns add replies, read replies and level change events;
// the final result of a command has last set. The cfg channel (cfg_valid /
// cfg_ready / cfg_data) writes the debounce threshold and is always ready.
// Add and read register their reply from the ADD or READ state once the output
// is free; remove acts at acceptance and gives no result. A tick walks all slots
// through the slot memory, one read per cycle while no older event is stuck,
// overlapped with the write-back of the previous slot; the END state then flushes
// the held event, and in_stall stays high through the walk and the flush. The
// single read and write port of the slot memory sets this pace, and a stalled
// event holds the walk. Events leave in slot order, each one held back until the
// next is found so that last can be marked.
// Reset empties the table (all slots vacant), sets the threshold to 5 and drops
// any pending result; slot memory contents are not cleared, as every slot is
// written when it is bound. While the receiver stalls, the output register holds
// its transaction; the block still accepts commands and stops only
// when it has a result to hand over.
module multi_slot_button_debouncer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  msbd_pkg::msbd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output msbd_pkg::msbd_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  msbd_pkg::state_t      state_r, state_nxt;
  msbd_pkg::msbd_in_t    in_r, in_nxt;
  logic [msbd_pkg::THR_W-1:0] thr_r;
  logic [msbd_pkg::SLOTS-1:0] vacant_r, vacant_nxt;
  logic [msbd_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic                  rd_more_r, rd_more_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [msbd_pkg::SLOT_W-1:0] s1_idx_r, s1_idx_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [msbd_pkg::SLOT_W-1:0] pend_slot_r, pend_slot_nxt;
  logic                  pend_level_r, pend_level_nxt;
  logic                  out_valid_r, out_valid_nxt;
  msbd_pkg::msbd_out_t   out_r, out_nxt;

  msbd_pkg::slot_entry_t mem [msbd_pkg::SLOTS];
  msbd_pkg::slot_entry_t rd_data_r;
  logic                  mem_re, mem_we;
  logic [msbd_pkg::SLOT_W-1:0] mem_raddr, mem_waddr;
  msbd_pkg::slot_entry_t mem_wdata;

  logic                  push;
  msbd_pkg::msbd_out_t   push_data;
  logic                  out_free;

  logic                  free_found;
  logic [msbd_pkg::SLOT_W-1:0] free_idx;

  logic [msbd_pkg::THR_W-1:0] thr_eff;
  logic                  now_lvl;
  logic [msbd_pkg::COUNT_WIDTH-1:0] cnt_inc, cnt_new;
  logic                  toggle;
  logic                  walk_hold;
  logic                  sid_in_range;

  assign in_stall  = (state_r != msbd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign sid_in_range = ({1'b0, in_r.slot_id} < 6'(msbd_pkg::SLOTS));

  // Lowest vacant slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = msbd_pkg::SLOTS - 1; i >= 0; i--) begin
      if (vacant_r[i]) begin
        free_found = 1'b1;
        free_idx   = msbd_pkg::SLOT_W'(i);
      end
    end
  end

  // Debounce update for the slot whose entry has just been read
  always_comb begin
    thr_eff = (thr_r == '0) ? msbd_pkg::THR_W'(1) : thr_r;
    now_lvl = msbd_pkg::sample_bit(in_r.gpio_levels, rd_data_r.port, rd_data_r.pin);
    cnt_inc = (&rd_data_r.count) ? rd_data_r.count
                                 : rd_data_r.count + msbd_pkg::COUNT_WIDTH'(1);
    cnt_new = (now_lvl != rd_data_r.stable) ? cnt_inc : '0;
    toggle  = ({{(16 - msbd_pkg::COUNT_WIDTH){1'b0}}, cnt_new} >=
               {{(16 - msbd_pkg::THR_W){1'b0}}, thr_eff});
  end

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    vacant_nxt     = vacant_r;
    idx_nxt        = idx_r;
    rd_more_nxt    = rd_more_r;
    s1_valid_nxt   = s1_valid_r;
    s1_idx_nxt     = s1_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_level_nxt = pend_level_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    push           = 1'b0;
    push_data      = '0;
    walk_hold      = 1'b0;

    unique case (state_r)
      msbd_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          unique case (msbd_pkg::kind_t'(in_data.kind))
            msbd_pkg::KIND_TICK: begin
              idx_nxt        = '0;
              rd_more_nxt    = 1'b1;
              s1_valid_nxt   = 1'b0;
              pend_valid_nxt = 1'b0;
              state_nxt      = msbd_pkg::ST_WALK;
            end
            msbd_pkg::KIND_ADD: begin
              state_nxt = msbd_pkg::ST_ADD;
            end
            msbd_pkg::KIND_REMOVE: begin
              if ({1'b0, in_data.slot_id} < 6'(msbd_pkg::SLOTS)) begin
                vacant_nxt[in_data.slot_id[msbd_pkg::SLOT_W-1:0]] = 1'b1;
              end
            end
            msbd_pkg::KIND_READ: begin
              mem_re    = 1'b1;
              mem_raddr = in_data.slot_id[msbd_pkg::SLOT_W-1:0];
              state_nxt = msbd_pkg::ST_READ;
            end
            default: state_nxt = msbd_pkg::ST_IDLE;
          endcase
        end
      end

      msbd_pkg::ST_ADD: begin
        if (out_free) begin
          push                 = 1'b1;
          push_data.reply_kind = msbd_pkg::REPLY_ADD;
          push_data.slot_num   = free_found ? 6'({1'b0, free_idx}) + 6'd1 : 6'd0;
          push_data.level      = 1'b0;
          push_data.last       = 1'b1;
          if (free_found) begin
            mem_we               = 1'b1;
            mem_waddr            = free_idx;
            mem_wdata.port       = in_r.port_sel;
            mem_wdata.pin        = in_r.pin_sel;
            mem_wdata.stable     = msbd_pkg::sample_bit(in_r.gpio_levels, in_r.port_sel,
                                                        in_r.pin_sel);
            mem_wdata.count      = '0;
            vacant_nxt[free_idx] = 1'b0;
          end
          state_nxt = msbd_pkg::ST_IDLE;
        end
      end

      msbd_pkg::ST_READ: begin
        if (out_free) begin
          push                 = 1'b1;
          push_data.reply_kind = msbd_pkg::REPLY_READ;
          push_data.slot_num   = 6'(in_r.slot_id);
          push_data.level      = sid_in_range &&
                                 !vacant_r[in_r.slot_id[msbd_pkg::SLOT_W-1:0]] &&
                                 rd_data_r.stable;
          push_data.last       = 1'b1;
          state_nxt            = msbd_pkg::ST_IDLE;
        end
      end

      msbd_pkg::ST_WALK: begin
        // Hold the whole walk while an older event cannot leave
        walk_hold = s1_valid_r && toggle && pend_valid_r && !out_free;
        if (!walk_hold) begin
          if (s1_valid_r) begin
            mem_we           = 1'b1;
            mem_waddr        = s1_idx_r;
            mem_wdata        = rd_data_r;
            mem_wdata.count  = toggle ? '0 : cnt_new;
            mem_wdata.stable = rd_data_r.stable ^ toggle;
            if (toggle) begin
              if (pend_valid_r) begin
                push                 = 1'b1;
                push_data.reply_kind = msbd_pkg::REPLY_EVENT;
                push_data.slot_num   = 6'(pend_slot_r);
                push_data.level      = pend_level_r;
                push_data.last       = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_slot_nxt  = s1_idx_r;
              pend_level_nxt = !rd_data_r.stable;
            end
          end
          s1_valid_nxt = 1'b0;
          if (rd_more_r) begin
            if (!vacant_r[idx_r]) begin
              mem_re       = 1'b1;
              mem_raddr    = idx_r;
              s1_valid_nxt = 1'b1;
              s1_idx_nxt   = idx_r;
            end
            if (idx_r == msbd_pkg::SLOT_W'(msbd_pkg::SLOTS - 1)) begin
              rd_more_nxt = 1'b0;
            end else begin
              idx_nxt = idx_r + msbd_pkg::SLOT_W'(1);
            end
          end else if (!s1_valid_r) begin
            state_nxt = msbd_pkg::ST_END;
          end
        end
      end

      msbd_pkg::ST_END: begin
        if (!pend_valid_r) begin
          state_nxt = msbd_pkg::ST_IDLE;
        end else if (out_free) begin
          push                 = 1'b1;
          push_data.reply_kind = msbd_pkg::REPLY_EVENT;
          push_data.slot_num   = 6'(pend_slot_r);
          push_data.level      = pend_level_r;
          push_data.last       = 1'b1;
          pend_valid_nxt       = 1'b0;
          state_nxt            = msbd_pkg::ST_IDLE;
        end
      end

      default: state_nxt = msbd_pkg::ST_IDLE;
    endcase

    // Output register: load on push, drop once taken
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_data;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= msbd_pkg::ST_IDLE;
      thr_r        <= msbd_pkg::THR_RESET;
      vacant_r     <= '1;
      rd_more_r    <= 1'b0;
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      vacant_r     <= vacant_nxt;
      rd_more_r    <= rd_more_nxt;
      s1_valid_r   <= s1_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r           <= in_nxt;
    s1_idx_r       <= s1_idx_nxt;
    pend_slot_r    <= pend_slot_nxt;
    pend_level_r   <= pend_level_nxt;
    out_r          <= out_nxt;
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

// ----- sv/msbd_checker.sv -----
// Port-level checks for the multi-slot button debouncer, bound to the top level.
module msbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input msbd_pkg::msbd_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input msbd_pkg::msbd_out_t out_data
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Any command but remove keeps the block busy in the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.kind != msbd_pkg::KIND_REMOVE) |=> in_stall)
    else $error("block idle right after a command with results");

  // Add and read replies are single results
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.reply_kind == msbd_pkg::REPLY_ADD) ||
                  (out_data.reply_kind == msbd_pkg::REPLY_READ)) |-> out_data.last)
    else $error("reply without last");

  // Add replies carry level zero and a slot number no greater than the table size
  a_add_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.reply_kind == msbd_pkg::REPLY_ADD) |->
      !out_data.level && (out_data.slot_num <= 6'(msbd_pkg::SLOTS)))
    else $error("malformed add reply");

  // Events name a real slot
  a_event_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.reply_kind == msbd_pkg::REPLY_EVENT) |->
      (out_data.slot_num < 6'(msbd_pkg::SLOTS)))
    else $error("event slot out of range");

endmodule

bind multi_slot_button_debouncer_unit msbd_checker u_msbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the multi-slot button debouncer unit.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 5000;  // cycles without any transaction before giving up
  localparam int DRAIN_WAIT  = 40;    // outlasts the time a tick keeps the block busy

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  msbd_pkg::msbd_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  msbd_pkg::msbd_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = '0;

  always #5 clk = ~clk;

  multi_slot_button_debouncer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow of the slot table and threshold
  bit [msbd_pkg::SLOTS-1:0]       vacant = '1;
  bit [1:0]                       bind_port [msbd_pkg::SLOTS];
  bit [3:0]                       bind_pin [msbd_pkg::SLOTS];
  bit                             stable_lvl [msbd_pkg::SLOTS];
  bit [msbd_pkg::COUNT_WIDTH-1:0] diff_count [msbd_pkg::SLOTS];
  bit [7:0]                       threshold = msbd_pkg::THR_RESET;

  msbd_pkg::msbd_in_t  cmd_backlog [$];
  msbd_pkg::msbd_out_t due_results [$];
  msbd_pkg::msbd_out_t held_res;
  bit        held_ok = 1'b0;
  int        queued = 0;
  int        errors = 0;
  int        in_gap = 0;
  int        stall_left = 0;
  int        calm_left = 0;
  bit        calm = 1'b0;
  int        quiet_cycles = 0;

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold each result back until the next one is known, so last can be marked
  function automatic void emit(msbd_pkg::reply_kind_t k, int slot, bit lvl);
    if (held_ok) due_results.push_back(held_res);
    held_res.reply_kind = k;
    held_res.slot_num   = 6'(slot);
    held_res.level      = lvl;
    held_res.last       = 1'b0;
    held_ok = 1'b1;
  endfunction

  function automatic void debounce_predict(msbd_pkg::msbd_in_t it);
    bit [7:0] eff;
    bit       now;
    int       reply;
    eff = (threshold == 0) ? 8'd1 : threshold;
    case (it.kind)
      msbd_pkg::KIND_TICK: begin
        for (int i = 0; i < msbd_pkg::SLOTS; i++) begin
          if (!vacant[i]) begin
            now = it.gpio_levels[{bind_port[i], bind_pin[i]}];
            if (now != stable_lvl[i]) begin
              if (diff_count[i] != '1) diff_count[i]++;
            end else begin
              diff_count[i] = '0;
            end
            if (diff_count[i] >= eff) begin
              stable_lvl[i] = ~stable_lvl[i];
              diff_count[i] = '0;
              emit(msbd_pkg::REPLY_EVENT, i, stable_lvl[i]);
            end
          end
        end
      end
      msbd_pkg::KIND_ADD: begin
        reply = 0;
        for (int i = 0; i < msbd_pkg::SLOTS; i++) begin
          if (vacant[i]) begin
            bind_port[i]  = it.port_sel;
            bind_pin[i]   = it.pin_sel;
            stable_lvl[i] = it.gpio_levels[{it.port_sel, it.pin_sel}];
            diff_count[i] = '0;
            vacant[i]     = 1'b0;
            reply = i + 1;
            break;
          end
        end
        emit(msbd_pkg::REPLY_ADD, reply, 1'b0);
      end
      msbd_pkg::KIND_REMOVE: vacant[it.slot_id] = 1'b1;
      default: emit(msbd_pkg::REPLY_READ, it.slot_id,
                    vacant[it.slot_id] ? 1'b0 : stable_lvl[it.slot_id]);
    endcase
    if (held_ok) begin
      held_res.last = 1'b1;
      due_results.push_back(held_res);
      held_ok = 1'b0;
    end
  endfunction

  function automatic void push_cmd(msbd_pkg::kind_t k, logic [63:0] lv, logic [1:0] pt,
                                   logic [3:0] pn, logic [4:0] sid);
    msbd_pkg::msbd_in_t it;
    it.kind        = k;
    it.gpio_levels = lv;
    it.port_sel    = pt;
    it.pin_sel     = pn;
    it.slot_id     = sid;
    cmd_backlog.push_back(it);
    queued++;
  endfunction

  function automatic void push_tick(logic [63:0] lv);
    push_cmd(msbd_pkg::KIND_TICK, lv, 2'($urandom()), 4'($urandom()), 5'($urandom()));
  endfunction

  function automatic void push_add(logic [63:0] lv, logic [1:0] pt, logic [3:0] pn);
    push_cmd(msbd_pkg::KIND_ADD, lv, pt, pn, 5'($urandom()));
  endfunction

  function automatic void push_slot_cmd(msbd_pkg::kind_t k, logic [4:0] sid);
    push_cmd(k, rnd64(), 2'($urandom()), 4'($urandom()), sid);
  endfunction

  // One random sequence; run_max bounds the length of a steady press
  function automatic void scenario(int run_max);
    int r;
    logic [63:0] lv;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // steady levels with the odd bounce
      lv = rnd64();
      repeat ($urandom_range(1, run_max)) begin
        if ($urandom_range(0, 9) == 0) push_tick(lv ^ rnd64());
        else push_tick(lv);
      end
    end else if (r < 60) begin
      repeat ($urandom_range(1, 4)) push_add(rnd64(), 2'($urandom()), 4'($urandom()));
    end else if (r < 64) begin
      // fill the table and overflow it
      repeat (msbd_pkg::SLOTS + 1) push_add(rnd64(), 2'($urandom()), 4'($urandom()));
    end else if (r < 78) begin
      repeat ($urandom_range(1, 3)) push_slot_cmd(msbd_pkg::KIND_REMOVE, 5'($urandom()));
    end else if (r < 92) begin
      push_slot_cmd(msbd_pkg::KIND_READ, 5'($urandom()));
    end else begin
      push_cmd(msbd_pkg::kind_t'($urandom_range(0, 3)), rnd64(), 2'($urandom()),
               4'($urandom()), 5'($urandom()));
    end
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Alternate between stretches with and without idling
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(50, 300);
    end else begin
      calm_left--;
    end
  end

  always @(posedge clk) begin : drive
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) debounce_predict(in_data);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          in_data  <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_gap = calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    msbd_pkg::msbd_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d slot %0d level %0d last %0d", $time,
                   out_data.reply_kind, out_data.slot_num, out_data.level, out_data.last);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("reply_kind", want.reply_kind, out_data.reply_kind);
          check_field("slot_num", want.slot_num, out_data.slot_num);
          check_field("level", want.level, out_data.level);
          check_field("last", want.last, out_data.last);
        end
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stim
    bit [7:0]    thr_set [6];
    bit [7:0]    eff;
    int          start;
    logic [63:0] lv;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset threshold
    push_slot_cmd(msbd_pkg::KIND_READ, 5'd0);    // vacant slot reads 0
    push_slot_cmd(msbd_pkg::KIND_READ, 5'd31);
    push_tick(rnd64());                          // empty table: no events
    push_slot_cmd(msbd_pkg::KIND_REMOVE, 5'd7);  // remove of a vacant slot
    push_add(64'h0, 2'd0, 4'd0);
    push_add('1, 2'd3, 4'd15);
    push_add(rnd64(), 2'd2, 4'd5);
    lv = 64'h0000_0000_0000_0001;
    repeat (3) push_tick(lv);
    push_tick(64'h8000_0000_0000_0000);          // matching levels clear the counters
    repeat (5) push_tick(lv);
    push_slot_cmd(msbd_pkg::KIND_READ, 5'd0);
    push_slot_cmd(msbd_pkg::KIND_READ, 5'd1);
    push_slot_cmd(msbd_pkg::KIND_REMOVE, 5'd0);
    push_slot_cmd(msbd_pkg::KIND_READ, 5'd0);
    push_slot_cmd(msbd_pkg::KIND_REMOVE, 5'd0);
    push_add('1, 2'd1, 4'd8);                    // reuses the lowest vacant slot
    push_slot_cmd(msbd_pkg::KIND_READ, 5'd0);
    drain();

    thr_set = '{8'd1, 8'd0, 8'd2, 8'd3, 8'($urandom_range(4, 12)), 8'd255};
    foreach (thr_set[p]) begin
      write_threshold(thr_set[p]);
      eff = (thr_set[p] == 0) ? 8'd1 : thr_set[p];
      if (thr_set[p] == 8'd255) begin
        // long steady run to reach the top threshold
        repeat (3) push_add(rnd64(), 2'($urandom()), 4'($urandom()));
        lv = rnd64();
        repeat (256) push_tick(lv);
        repeat (2) push_slot_cmd(msbd_pkg::KIND_READ, 5'($urandom()));
      end
      start = queued;
      while (queued - start < 25) scenario((eff > 12) ? 6 : eff + 3);
      drain();
    end

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
